>>> rtl/core/rbcs_pkg.sv
package rbcs_pkg;

    // bitmap organization: one memory word holds WORD_W pixels of one row
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;

    // field and register widths
    localparam int POS_W    = 10;
    localparam int DIM_W    = 11;
    localparam int EDGE_W   = 6;
    localparam int OP_W     = 2;
    localparam int CW       = 12;   // coordinate arithmetic: origin plus edge
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 24;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // default bitmap and block limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_BLOCK  = 32;

    // register reset values
    localparam logic [DIM_W-1:0]  FRAME_W_RST = 11'd1024;
    localparam logic [DIM_W-1:0]  FRAME_H_RST = 11'd1024;
    localparam logic [EDGE_W-1:0] EDGE_RST    = 6'd16;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_TEST  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        REG_FRAME_W    = 2'd0,
        REG_FRAME_H    = 2'd1,
        REG_BLOCK_EDGE = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_COVER,
        S_FLUSH
    } t_state;

endpackage

>>> rtl/core/rbcs_bitmap_ram.sv
module rbcs_bitmap_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = rbcs_pkg::WORD_W
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/residual_block_cover_scan.sv
// Residual block cover scan: per-pixel coverage bitmap of one frame.
// Input stream (s_axis): one word per command. tuser[1:0] opcode (clear, mark,
// test), tuser[2] block_valid; tdata[9:0] pos_x, tdata[19:10] pos_y.
// Output stream (m_axis): one word per test pixel that was still uncovered,
// tdata[9:0] origin_x, tdata[19:10] origin_y.
// APB port: frame_width at 0x0, frame_height at 0x4, block_edge at 0x8;
// write only while the block is idle.
// Timing: commands are handled one at a time, tready is high only when idle.
// Clear sweeps the whole bitmap memory, one word per cycle. Mark walks every
// bitmap word touched (clipped rows times 1..2 words per row with default
// limits), reading each and writing back its merge. Test stops after decode
// when the pixel is outside the frame, after the check when it is covered, else
// goes on to the cover walk. The bitmap memory has one read and one write port.
// Reset runs the same clear sweep; no command is accepted until it finishes,
// while APB writes are taken at any time.
// A result sits in an output register; if the receiver stalls, a test that
// finds another uncovered pixel waits until that register is free and holds
// off all later commands, while marks and covered tests before it keep flowing.
module residual_block_cover_scan #(
    parameter int MAX_WIDTH  = rbcs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbcs_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = rbcs_pkg::DEF_MAX_BLOCK
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command words
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [rbcs_pkg::S_DATA_W-1:0] i_s_axis_tdata,  // pos_x, pos_y, zero pad
    input  logic [rbcs_pkg::S_USER_W-1:0] i_s_axis_tuser,  // opcode, block_valid
    // residual block origins
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [rbcs_pkg::M_DATA_W-1:0] o_m_axis_tdata,  // origin_x, origin_y, zero pad
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbcs_pkg::APB_AW-1:0]   paddr,
    input  logic [rbcs_pkg::APB_DW-1:0]   pwdata,
    output logic [rbcs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int WORD_W = rbcs_pkg::WORD_W;
    localparam int WSH    = rbcs_pkg::WORD_SH;
    localparam int CW     = rbcs_pkg::CW;
    localparam int POS_W  = rbcs_pkg::POS_W;
    localparam int DIM_W  = rbcs_pkg::DIM_W;
    localparam int EDGE_W = rbcs_pkg::EDGE_W;
    // words per bitmap row, row index and address widths
    localparam int WPR = (MAX_WIDTH + WORD_W - 1) / WORD_W;
    localparam int WW  = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW  = YW + WW;

    rbcs_pkg::t_state r_state, n_state;

    // configuration registers
    logic [DIM_W-1:0]  r_frame_w, r_frame_h;
    logic [EDGE_W-1:0] r_edge;

    // captured command
    logic [1:0]       r_op;
    logic             r_blk_vld;
    logic [POS_W-1:0] r_x, r_y;

    // clipped square, decoded once per command
    logic [CW-1:0] d_w, d_h, d_e, d_x_sum, d_y_sum, d_x_end, d_y_end, d_x_last, d_y_last;
    logic          d_in_frame;
    logic [WW-1:0]  r_kw0, r_kw1;
    logic [WSH-1:0] r_lo5, r_hi5;
    logic [YW-1:0]  r_y_last;

    // cover walk and write-back stage
    logic [YW-1:0]     r_cy;
    logic [WW-1:0]     r_cw;
    logic              r_wb_vld;
    logic [AW-1:0]     r_wb_addr;
    logic [WORD_W-1:0] r_wb_mask;
    logic [WORD_W-1:0] c_mask;
    logic [WSH-1:0]    c_lo, c_hi;
    logic              c_last;

    // clear sweep
    logic [AW-1:0] r_clr_addr;

    // output register
    logic             r_out_vld;
    logic [POS_W-1:0] r_out_x, r_out_y;

    // memory ports
    logic              ram_rd_en, ram_wr_en;
    logic [AW-1:0]     ram_rd_addr, ram_wr_addr;
    logic [WORD_W-1:0] ram_rd_data, ram_wr_data;

    logic s_accept, cfg_wr, px_covered, out_load;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= rbcs_pkg::FRAME_W_RST;
            r_frame_h <= rbcs_pkg::FRAME_H_RST;
            r_edge    <= rbcs_pkg::EDGE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                rbcs_pkg::REG_FRAME_W:    r_frame_w <= pwdata[DIM_W-1:0];
                rbcs_pkg::REG_FRAME_H:    r_frame_h <= pwdata[DIM_W-1:0];
                rbcs_pkg::REG_BLOCK_EDGE: r_edge    <= pwdata[EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rbcs_pkg::REG_FRAME_W:    prdata = 32'(r_frame_w);
            rbcs_pkg::REG_FRAME_H:    prdata = 32'(r_frame_h);
            rbcs_pkg::REG_BLOCK_EDGE: prdata = 32'(r_edge);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- command capture ----------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op      <= i_s_axis_tuser[1:0];
            r_blk_vld <= i_s_axis_tuser[2];
            r_x       <= i_s_axis_tdata[POS_W-1:0];
            r_y       <= i_s_axis_tdata[2*POS_W-1:POS_W];
        end
    end

    // ---------------- clipping ----------------
    // saturate frame to the bitmap, edge to 1..MAX_BLOCK
    always_comb begin
        d_w = (32'(r_frame_w) > 32'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(r_frame_w);
        d_h = (32'(r_frame_h) > 32'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(r_frame_h);
        if (r_edge == '0) begin
            d_e = CW'(1);
        end else if (32'(r_edge) > 32'(MAX_BLOCK)) begin
            d_e = CW'(MAX_BLOCK);
        end else begin
            d_e = CW'(r_edge);
        end
        d_in_frame = (CW'(r_x) < d_w) && (CW'(r_y) < d_h);
        d_x_sum  = CW'(r_x) + d_e;
        d_y_sum  = CW'(r_y) + d_e;
        d_x_end  = (d_x_sum > d_w) ? d_w : d_x_sum;
        d_y_end  = (d_y_sum > d_h) ? d_h : d_y_sum;
        d_x_last = d_x_end - CW'(1);
        d_y_last = d_y_end - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rbcs_pkg::S_DECODE) begin
            r_kw0    <= WW'(r_x >> WSH);
            r_kw1    <= WW'(d_x_last >> WSH);
            r_lo5    <= r_x[WSH-1:0];
            r_hi5    <= d_x_last[WSH-1:0];
            r_y_last <= YW'(d_y_last);
        end
    end

    // ---------------- cover walk ----------------
    // bits of the current word that fall inside [x0, x_end)
    always_comb begin
        c_lo   = (r_cw == r_kw0) ? r_lo5 : '0;
        c_hi   = (r_cw == r_kw1) ? r_hi5 : '1;
        c_mask = ({WORD_W{1'b1}} << c_lo) & ({WORD_W{1'b1}} >> (WSH'(WORD_W - 1) - c_hi));
        c_last = (r_cy == r_y_last) && (r_cw == r_kw1);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rbcs_pkg::S_DECODE) begin
            r_cy <= YW'(r_y);
            r_cw <= WW'(r_x >> WSH);
        end else if (r_state == rbcs_pkg::S_COVER) begin
            if (r_cw == r_kw1) begin
                r_cw <= r_kw0;
                r_cy <= r_cy + YW'(1);
            end else begin
                r_cw <= r_cw + WW'(1);
            end
        end
    end

    // one word read per cycle; its merge is written back the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
        end else begin
            r_wb_vld <= (r_state == rbcs_pkg::S_COVER);
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= {r_cy, r_cw};
        r_wb_mask <= c_mask;
    end

    // ---------------- clear sweep ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == rbcs_pkg::S_CLEAR) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // ---------------- test and result ----------------
    assign px_covered = ram_rd_data[r_x[WSH-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x <= r_x;
            r_out_y <= r_y;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'b0, r_out_y, r_out_x};

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbcs_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rbcs_pkg::S_CLEAR: begin
                if (r_clr_addr == '1) n_state = rbcs_pkg::S_IDLE;
            end
            rbcs_pkg::S_IDLE: begin
                if (s_accept) n_state = rbcs_pkg::S_DECODE;
            end
            rbcs_pkg::S_DECODE: begin
                case (r_op)
                    rbcs_pkg::OP_CLEAR: n_state = rbcs_pkg::S_CLEAR;
                    rbcs_pkg::OP_MARK: begin
                        n_state = (r_blk_vld && d_in_frame) ? rbcs_pkg::S_COVER
                                                            : rbcs_pkg::S_IDLE;
                    end
                    rbcs_pkg::OP_TEST: begin
                        n_state = d_in_frame ? rbcs_pkg::S_CHECK : rbcs_pkg::S_IDLE;
                    end
                    default: n_state = rbcs_pkg::S_IDLE;
                endcase
            end
            rbcs_pkg::S_CHECK: begin
                if (px_covered) begin
                    n_state = rbcs_pkg::S_IDLE;
                end else if (out_load) begin
                    n_state = rbcs_pkg::S_COVER;
                end
            end
            rbcs_pkg::S_COVER: begin
                if (c_last) n_state = rbcs_pkg::S_FLUSH;
            end
            rbcs_pkg::S_FLUSH: n_state = rbcs_pkg::S_IDLE;
            default:           n_state = rbcs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        out_load        = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = {r_cy, r_cw};
        ram_wr_en       = 1'b0;
        ram_wr_addr     = r_wb_addr;
        ram_wr_data     = ram_rd_data | r_wb_mask;
        case (r_state)
            rbcs_pkg::S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
            end
            rbcs_pkg::S_IDLE: o_s_axis_tready = 1'b1;
            rbcs_pkg::S_DECODE: begin
                // fetch the word holding the test pixel
                ram_rd_en   = (r_op == rbcs_pkg::OP_TEST);
                ram_rd_addr = {YW'(r_y), WW'(r_x >> WSH)};
            end
            rbcs_pkg::S_CHECK: begin
                out_load = !px_covered && (!r_out_vld || i_m_axis_tready);
            end
            rbcs_pkg::S_COVER: begin
                ram_rd_en = 1'b1;
                ram_wr_en = r_wb_vld;
            end
            rbcs_pkg::S_FLUSH: ram_wr_en = r_wb_vld;
            default: ;
        endcase
    end

    rbcs_bitmap_ram #(
        .ADDR_W (AW),
        .DATA_W (WORD_W)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

endmodule

>>> verif/tb_residual_block_cover_scan.sv
`timescale 1ns / 1ps

module tb_residual_block_cover_scan;
    import rbcs_pkg::*;

    // Worst case: about 18 full-bitmap sweeps, plus about 2000 words that may each
    // start a 32-row cover walk, plus long sender gaps and receiver stalls. The
    // limit allows four times the total this adds up to.
    localparam int         LIMIT_CYCLES = 4_000_000;
    localparam int         LONG_HOLD    = 4000;  // receiver blackout, in cycles
    localparam int         HOLD_AFTER   = 60;    // origins seen before the blackout
    localparam int         MAX_REPORTS  = 40;
    localparam int         POS_MAX      = (1 << POS_W) - 1;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             valid;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] ox;
        logic [POS_W-1:0] oy;
    } origin_t;

    // ---------------------------------------------------------------- DUT ports
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    wire                 o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata  = '0;  // pos_x, pos_y, zero pad
    logic [S_USER_W-1:0] i_s_axis_tuser  = '0;  // opcode, block_valid
    wire                 o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    wire  [M_DATA_W-1:0] o_m_axis_tdata;        // origin_x, origin_y, zero pad
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [APB_AW-1:0]   paddr           = '0;
    logic [APB_DW-1:0]   pwdata          = '0;
    wire  [APB_DW-1:0]   prdata;
    wire                 pready;

    residual_block_cover_scan i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------- bitmap predictor
    // One packed row per frame line; a set bit means the pixel is already covered.
    bit [DEF_MAX_WIDTH-1:0] cov_rows [DEF_MAX_HEIGHT];
    logic [DIM_W-1:0]       reg_frame_w = FRAME_W_RST;
    logic [DIM_W-1:0]       reg_frame_h = FRAME_H_RST;
    logic [EDGE_W-1:0]      reg_edge    = EDGE_RST;

    cmd_t    cmd_backlog [$];   // words waiting for the driver
    origin_t due_origins [$];   // residual origins the block still owes us

    int  words_queued   = 0;
    int  words_accepted = 0;
    int  n_tests        = 0;
    int  n_marks        = 0;
    int  n_clears       = 0;
    int  n_unused       = 0;
    int  n_origins      = 0;
    int  n_settings     = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    bit  no_idle        = 1'b0;

    // The frame in use saturates at the bitmap size.
    function automatic int frame_cols();
        return (reg_frame_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(reg_frame_w);
    endfunction

    function automatic int frame_rows();
        return (reg_frame_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(reg_frame_h);
    endfunction

    // Edge 0 acts as 1, anything past the limit acts as the limit.
    function automatic int square_edge();
        if (reg_edge == 0)
            return 1;
        return (reg_edge > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : int'(reg_edge);
    endfunction

    // Flag the square at (x0, y0), clipped to the frame; origin outside does nothing.
    function automatic void cover_square(input int x0, input int y0);
        int w, h, e, xe, ye;
        w = frame_cols();
        h = frame_rows();
        e = square_edge();
        if (x0 >= w || y0 >= h)
            return;
        xe = (x0 + e > w) ? w : x0 + e;
        ye = (y0 + e > h) ? h : y0 + e;
        for (int y = y0; y < ye; y++)
            for (int x = x0; x < xe; x++)
                cov_rows[POS_W'(y)][POS_W'(x)] = 1'b1;
    endfunction

    // Advance the bitmap by one accepted word and queue the origin it owes, if any.
    function automatic void apply_to_bitmap(input cmd_t c);
        origin_t hit;
        case (c.op)
            OP_CLEAR: begin
                n_clears++;
                foreach (cov_rows[r])
                    cov_rows[r] = '0;
            end
            OP_MARK: begin
                n_marks++;
                if (c.valid)
                    cover_square(c.px, c.py);
            end
            OP_TEST: begin
                n_tests++;
                if (c.px < frame_cols() && c.py < frame_rows() && !cov_rows[c.py][c.px]) begin
                    cover_square(c.px, c.py);
                    hit.ox = c.px;
                    hit.oy = c.py;
                    due_origins.push_back(hit);
                end
            end
            default: begin
                n_unused++;
            end
        endcase
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    // ------------------------------------------------------------ timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("residual_block_cover_scan regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------- driver
    // Pop words from the backlog, hold each until the block takes it, then
    // wait out a random gap. Prediction happens at the accepting edge.
    cmd_t cur_cmd;
    bit   drv_busy;
    int   gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            drv_busy = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_to_bitmap(cur_cmd);
                words_accepted++;
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() > 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    i_s_axis_tdata <= {{(S_DATA_W - 2 * POS_W){1'b0}}, cur_cmd.py, cur_cmd.px};
                    i_s_axis_tuser <= {cur_cmd.valid, cur_cmd.op};
                    drv_busy = 1'b1;
                    gap_left = no_idle ? 0 : gap_len();
                end
            end
            // single assignment per edge keeps tvalid steady across back-to-back words
            i_s_axis_tvalid <= drv_busy;
        end
    end

    // ------------------------------------------------------------ monitor
    // Check each accepted origin against the oldest one owed, and drive the
    // receiver's ready with random stalls plus one long blackout.
    origin_t got, want;
    bit      rdy_next;
    bit      long_hold_done = 1'b0;
    int      rdy_hold       = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rdy_hold = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.ox = o_m_axis_tdata[POS_W-1:0];
                got.oy = o_m_axis_tdata[2*POS_W-1:POS_W];
                n_origins++;
                if (due_origins.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $error("origin (%0d,%0d) arrived with none outstanding", got.ox, got.oy);
                    mismatches++;
                end else begin
                    want = due_origins.pop_front();
                    if (got.ox !== want.ox) begin
                        if (mismatches < MAX_REPORTS)
                            $error("origin_x expected %0d got %0d", want.ox, got.ox);
                        mismatches++;
                    end
                    if (got.oy !== want.oy) begin
                        if (mismatches < MAX_REPORTS)
                            $error("origin_y expected %0d got %0d", want.oy, got.oy);
                        mismatches++;
                    end
                end
            end

            if (rdy_hold > 0) begin
                rdy_hold--;
                rdy_next = 1'b0;
            end else if (!long_hold_done && n_origins >= HOLD_AFTER) begin
                // blackout: the sender keeps going until the block backs up
                long_hold_done = 1'b1;
                rdy_hold = LONG_HOLD;
                rdy_next = 1'b0;
            end else if (no_idle || $urandom_range(0, 99) < 65) begin
                rdy_next = 1'b1;
            end else begin
                rdy_hold = gap_len();
                rdy_next = 1'b0;
            end
            i_m_axis_tready <= rdy_next;
        end
    end

    // ----------------------------------------------------- stimulus helpers
    task automatic push_cmd(input logic [OP_W-1:0] op, input bit valid,
                            input int x, input int y);
        cmd_t c;
        c.op    = op;
        c.valid = valid;
        c.px    = POS_W'(x);
        c.py    = POS_W'(y);
        cmd_backlog.push_back(c);
        words_queued++;
    endtask

    // One APB transfer: setup, then access; read data is taken mid-access.
    task automatic apb_cycle(input bit wr, input t_reg_idx idx,
                             input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a register, mirror it in the predictor, read it back.
    task automatic set_reg(input t_reg_idx idx, input int val);
        logic [APB_DW-1:0] rd, wanted;
        apb_cycle(1'b1, idx, APB_DW'(val), rd);
        case (idx)
            REG_FRAME_W: begin
                reg_frame_w = DIM_W'(val);
                wanted = APB_DW'(reg_frame_w);
            end
            REG_FRAME_H: begin
                reg_frame_h = DIM_W'(val);
                wanted = APB_DW'(reg_frame_h);
            end
            default: begin
                reg_edge = EDGE_W'(val);
                wanted = APB_DW'(reg_edge);
            end
        endcase
        apb_cycle(1'b0, idx, '0, rd);
        if (rd !== wanted) begin
            if (mismatches < MAX_REPORTS)
                $error("register %s readback expected %0d got %0d", idx.name(), wanted, rd);
            mismatches++;
        end
    endtask

    task automatic set_frame(input int w, input int h, input int e);
        set_reg(REG_FRAME_W, w);
        set_reg(REG_FRAME_H, h);
        set_reg(REG_BLOCK_EDGE, e);
        n_settings++;
    endtask

    // Wait until every word is taken, every origin has arrived, and the
    // block is back to idle (a clear or a cover walk may still be running).
    task automatic drain();
        while (words_accepted != words_queued || due_origins.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        while (!o_s_axis_tready)
            @(negedge i_clk);
    endtask

    // Junk word: any opcode but clear, fields over their full range.
    task automatic push_noise(output bit counted);
        logic [OP_W-1:0] op;
        op = OP_W'($urandom_range(1, 3));
        push_cmd(op, 1'($urandom_range(0, 1)), $urandom_range(0, POS_MAX),
                 $urandom_range(0, POS_MAX));
        counted = (op != OP_UNUSED);
    endtask

    // Random part: mostly up to three random marks followed by a column-major scan
    // of a small window, the rest junk words and a rare clear.
    task automatic add_random_cmds(input int n);
        int made, w, h, x0, y0, cols, rows, nm, k, lim_x, lim_y;
        bit cleared, counted;
        made    = 0;
        cleared = 1'b0;
        w = frame_cols();
        h = frame_rows();
        lim_x = (w + 8 > POS_MAX) ? POS_MAX : w + 8;
        lim_y = (h + 8 > POS_MAX) ? POS_MAX : h + 8;
        while (made < n) begin
            k = $urandom_range(0, 99);
            if (k < 70) begin
                nm = $urandom_range(0, 3);
                for (int i = 0; i < nm; i++) begin
                    push_cmd(OP_MARK, ($urandom_range(0, 3) != 0),
                             $urandom_range(0, lim_x), $urandom_range(0, lim_y));
                    made++;
                end
                x0   = $urandom_range(0, w - 1);
                y0   = $urandom_range(0, h - 1);
                cols = $urandom_range(1, 6);
                rows = $urandom_range(1, 8);
                for (int x = x0; x < x0 + cols && x <= POS_MAX && made < n; x++) begin
                    for (int y = y0; y < y0 + rows && y <= POS_MAX && made < n; y++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            push_noise(counted);
                            if (counted)
                                made++;
                        end else begin
                            push_cmd(OP_TEST, 1'($urandom_range(0, 1)), x, y);
                            made++;
                        end
                    end
                end
            end else if (k < 97 || cleared) begin
                push_noise(counted);
                if (counted)
                    made++;
            end else begin
                push_cmd(OP_CLEAR, 1'($urandom_range(0, 1)),
                         $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
                cleared = 1'b1;
                made++;
            end
        end
    endtask

    // Start from an empty bitmap, then run a random batch under these settings.
    task automatic random_phase(input int w, input int h, input int e,
                                input int n, input bit calm);
        set_frame(w, h, e);
        no_idle = calm;
        push_cmd(OP_CLEAR, 1'b0, 0, 0);
        add_random_cmds(n);
        drain();
    endtask

    // ---------------------------------------------------------- test plan
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default-sized frame: basic cover, repeat hits, invalid mark, clipped
        // corner mark, unused opcode.
        set_frame(1024, 1024, 16);
        push_cmd(OP_CLEAR, 1'b0, 0, 0);
        push_cmd(OP_TEST, 1'b0, 0, 0);
        push_cmd(OP_TEST, 1'b0, 0, 0);
        push_cmd(OP_TEST, 1'b1, 15, 15);
        push_cmd(OP_TEST, 1'b0, 16, 0);
        push_cmd(OP_MARK, 1'b0, 100, 100);
        push_cmd(OP_TEST, 1'b0, 100, 100);
        push_cmd(OP_MARK, 1'b1, 1020, 1020);
        push_cmd(OP_TEST, 1'b0, POS_MAX, POS_MAX);
        push_cmd(OP_TEST, 1'b0, 1008, 1008);
        push_cmd(OP_UNUSED, 1'b1, POS_MAX, POS_MAX);
        push_cmd(OP_TEST, 1'b0, POS_MAX, 0);
        drain();

        // Oversized frame and edge saturate; the bitmap survives register writes.
        set_frame(2047, 2047, 63);
        push_cmd(OP_TEST, 1'b0, 500, 500);
        push_cmd(OP_TEST, 1'b0, 531, 531);
        push_cmd(OP_TEST, 1'b0, 532, 500);
        push_cmd(OP_MARK, 1'b1, POS_MAX, 0);
        push_cmd(OP_TEST, 1'b0, POS_MAX, 31);
        push_cmd(OP_TEST, 1'b0, 0, 0);
        drain();

        // Edge 0 acts as one pixel; tests and marks outside the frame do nothing.
        set_frame(30, 20, 0);
        push_cmd(OP_TEST, 1'b0, 29, 19);
        push_cmd(OP_TEST, 1'b0, 30, 0);
        push_cmd(OP_TEST, 1'b0, 0, 20);
        push_cmd(OP_MARK, 1'b1, 35, 40);
        drain();

        // Zero-width frame holds no pixel.
        set_frame(0, 20, 5);
        push_cmd(OP_TEST, 1'b0, 2, 30);
        push_cmd(OP_MARK, 1'b1, 40, 40);
        drain();

        // Neither of the dropped marks left a trace.
        set_frame(64, 64, 4);
        push_cmd(OP_TEST, 1'b0, 35, 40);
        push_cmd(OP_TEST, 1'b0, 40, 40);
        push_cmd(OP_MARK, 1'b1, 50, 50);
        push_cmd(OP_TEST, 1'b0, 53, 53);
        drain();

        random_phase(40, 24, 7, 260, 1'b0);
        random_phase(1024, 1024, 32, 300, 1'b0);
        random_phase(100, 64, 32, 260, 1'b1);
        random_phase(17, 1000, 3, 260, 1'b0);
        random_phase(1, 1, 1, 120, 1'b0);
        random_phase(1024, 1024, 1, 260, 1'b0);
        random_phase(2000, 700, 50, 260, 1'b1);
        random_phase(333, 2047, 12, 230, 1'b0);

        // trailing window: anything arriving now has no owner
        repeat (50) @(posedge i_clk);

        $display("ran %0d words (%0d tests, %0d marks, %0d clears, %0d unused opcodes)",
                 words_accepted, n_tests, n_marks, n_clears, n_unused);
        $display("checked %0d residual origins across %0d register settings in %0d cycles",
                 n_origins, n_settings, cycle_count);
        if (mismatches == 0) begin
            $display("residual_block_cover_scan regression: pass");
        end else begin
            $display("residual_block_cover_scan regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rbcs_pkg.sv
rtl/core/rbcs_bitmap_ram.sv
rtl/core/residual_block_cover_scan.sv
verif/tb_residual_block_cover_scan.sv
